[rtl/dss_pkg.sv]
// Package for the dual stack shared array block.
// Holds operation and status codes, fixed field widths, and controller/datapath bundles.
// No dependencies.
package dss_pkg;

	localparam int DATA_W  = 32;
	localparam int COUNT_W = 7;

	typedef enum logic [1:0] {
		OP_PUSH_LO = 2'd0,
		OP_POP_LO  = 2'd1,
		OP_PUSH_UP = 2'd2,
		OP_POP_UP  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_OVERFLOW  = 2'd1,
		STAT_UNDERFLOW = 2'd2
	} status_t;

	// command from controller to datapath
	typedef struct packed {
		logic write;
		logic read;
		logic upper;
	} dss_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic full;
		logic lower_empty;
		logic upper_empty;
	} dss_flags_t;

endpackage

[rtl/dss_ctrl.sv]
// Controller for the dual stack shared array: handshakes, operation decode, result register.
// Depends on dss_pkg.
module dss_ctrl
	import dss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  operation,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  status,
	output logic        pop_ok,
	input  dss_flags_t  flags,
	output dss_cmd_t    cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_HOLD
	} state_t;

	state_t  state_q;
	status_t status_q;
	status_t stat_d;
	logic    pop_ok_q;
	logic    accept;
	dss_cmd_t op_cmd;

	assign req_stall = (state_q == ST_HOLD) && rsp_stall;
	assign accept    = req_valid && !req_stall;

	always_comb begin
		op_cmd = '0;
		stat_d = STAT_OK;
		unique case (op_t'(operation))
			OP_PUSH_LO: begin
				if (flags.full) stat_d = STAT_OVERFLOW;
				else op_cmd.write = 1'b1;
			end
			OP_POP_LO: begin
				if (flags.lower_empty) stat_d = STAT_UNDERFLOW;
				else op_cmd.read = 1'b1;
			end
			OP_PUSH_UP: begin
				op_cmd.upper = 1'b1;
				if (flags.full) stat_d = STAT_OVERFLOW;
				else op_cmd.write = 1'b1;
			end
			OP_POP_UP: begin
				op_cmd.upper = 1'b1;
				if (flags.upper_empty) stat_d = STAT_UNDERFLOW;
				else op_cmd.read = 1'b1;
			end
			default: stat_d = STAT_OK;
		endcase
	end

	always_comb begin
		cmd       = op_cmd;
		cmd.write = op_cmd.write && accept;
		cmd.read  = op_cmd.read && accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			status_q <= STAT_OK;
			pop_ok_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q  <= ST_HOLD;
						status_q <= stat_d;
						pop_ok_q <= op_cmd.read;
					end
				end
				ST_HOLD: begin
					if (accept) begin
						status_q <= stat_d;
						pop_ok_q <= op_cmd.read;
					end else if (!rsp_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp_valid = (state_q == ST_HOLD);
	assign status    = status_q;
	assign pop_ok    = pop_ok_q;

endmodule

[rtl/dss_datapath.sv]
// Datapath for the dual stack shared array: storage memory, fill counters, address generation.
// Depends on dss_pkg.
module dss_datapath
	import dss_pkg::*;
#(
	parameter int DEPTH = 64
)(
	input  logic              clk,
	input  logic              arst_n,
	input  dss_cmd_t          cmd,
	input  logic [DATA_W-1:0] push_value,
	output logic [DATA_W-1:0] rd_data,
	output dss_flags_t        flags,
	output logic [COUNT_W-1:0] lower_count,
	output logic [COUNT_W-1:0] upper_count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_q;
	logic [FW-1:0]     lower_fill_q;
	logic [FW-1:0]     upper_fill_q;
	logic [FW:0]       used;
	logic [FW-1:0]     lo_addr;
	logic [FW-1:0]     up_addr;
	logic [FW-1:0]     addr_full;
	logic [AW-1:0]     addr;

	assign used = {1'b0, lower_fill_q} + {1'b0, upper_fill_q};

	assign flags.full        = (used >= (FW+1)'(DEPTH));
	assign flags.lower_empty = (lower_fill_q == '0);
	assign flags.upper_empty = (upper_fill_q == '0);

	assign lo_addr   = cmd.write ? lower_fill_q : lower_fill_q - FW'(1);
	assign up_addr   = cmd.write ? FW'(DEPTH - 1) - upper_fill_q : FW'(DEPTH) - upper_fill_q;
	assign addr_full = cmd.upper ? up_addr : lo_addr;
	assign addr      = addr_full[AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.write) mem[addr] <= push_value;
		if (cmd.read) rd_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_fill_q <= '0;
			upper_fill_q <= '0;
		end else begin
			if (cmd.upper) begin
				if (cmd.write) upper_fill_q <= upper_fill_q + FW'(1);
				else if (cmd.read) upper_fill_q <= upper_fill_q - FW'(1);
			end else begin
				if (cmd.write) lower_fill_q <= lower_fill_q + FW'(1);
				else if (cmd.read) lower_fill_q <= lower_fill_q - FW'(1);
			end
		end
	end

	assign rd_data     = rd_q;
	assign lower_count = COUNT_W'(lower_fill_q);
	assign upper_count = COUNT_W'(upper_fill_q);

endmodule

[rtl/dual_stack_shared_array.sv]
// Two stacks sharing one storage array: lower grows up from entry 0, upper down from the top.
// Top level; instantiates dss_ctrl and dss_datapath, depends on dss_pkg.
//
// Request channel: req_valid/req_stall with operation and push_value.
// Response channel: rsp_valid/rsp_stall with status, pop_value, lower_count, upper_count.
// Every request gives exactly one response. A transaction accepted at one edge
// shows its response from the next cycle on.
// Throughput: one transaction per cycle while the response side does not stall,
// set by the single-port storage memory (one read or one write per transaction)
// and the one-entry response register.
// Push: status overflow when the two stacks together hold DEPTH entries.
// Pop: status underflow when the chosen stack is empty; pop_value is zero unless
// a pop succeeds. Counts are the fills after the operation, reported in 7 bits.
// Reset empties both stacks and clears the response register; memory contents
// are not cleared and no clearing pass is needed.
// While the response is stalled it holds, and req_stall is raised so no new
// transaction is taken until the response is accepted.
module dual_stack_shared_array
	import dss_pkg::*;
#(
	parameter int DEPTH = 64
)(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  logic [1:0]                operation,
	input  logic signed [DATA_W-1:0]  push_value,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output logic [1:0]                status,
	output logic signed [DATA_W-1:0]  pop_value,
	output logic [COUNT_W-1:0]        lower_count,
	output logic [COUNT_W-1:0]        upper_count
);

	dss_cmd_t          cmd;
	dss_flags_t        flags;
	logic              pop_ok;
	logic [DATA_W-1:0] rd_data;

	dss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.operation (operation),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.pop_ok    (pop_ok),
		.flags     (flags),
		.cmd       (cmd)
	);

	dss_datapath #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.push_value  (push_value),
		.rd_data     (rd_data),
		.flags       (flags),
		.lower_count (lower_count),
		.upper_count (upper_count)
	);

	assign pop_value = pop_ok ? rd_data : '0;

endmodule

[rtl/dss_checker.sv]
// Port-level assertions for dual_stack_shared_array, attached by bind.
// Depends on dss_pkg.
module dss_port_checks
	import dss_pkg::*;
#(
	parameter int DEPTH = 64
)(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      req_valid,
	input logic                      req_stall,
	input logic [1:0]                operation,
	input logic                      rsp_valid,
	input logic                      rsp_stall,
	input logic [1:0]                status,
	input logic signed [DATA_W-1:0]  pop_value,
	input logic [COUNT_W-1:0]        lower_count,
	input logic [COUNT_W-1:0]        upper_count
);

	logic req_acc;
	assign req_acc = req_valid && !req_stall;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(pop_value))
		else $error("stalled response changed");

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> rsp_valid)
		else $error("accepted transaction gave no response");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != STAT_OK) |-> pop_value == '0)
		else $error("failed operation returned a nonzero value");

	a_push_lo_count: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && (operation == OP_PUSH_LO) |=>
		((status == STAT_OK) && (lower_count == COUNT_W'($past(lower_count) + 1'b1))) ||
		((status == STAT_OVERFLOW) && $stable(lower_count) && $stable(upper_count)))
		else $error("lower push count mismatch");

endmodule

bind dual_stack_shared_array dss_port_checks #(.DEPTH(DEPTH)) u_dss_checker (.*);

[tb/sv/dss_checker.sv]
// Checker for dual_stack_shared_array: watches both channels, predicts each response.
// Keeps its own copy of the shared array and both fill counts; uses dss_pkg codes.
`timescale 1ns / 100ps
module dss_checker
	import dss_pkg::*;
#(
	parameter int DEPTH = 64
)(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	input  logic                      req_stall,
	input  logic [1:0]                operation,
	input  logic signed [DATA_W-1:0]  push_value,
	input  logic                      rsp_valid,
	input  logic                      rsp_stall,
	input  logic [1:0]                status,
	input  logic signed [DATA_W-1:0]  pop_value,
	input  logic [COUNT_W-1:0]        lower_count,
	input  logic [COUNT_W-1:0]        upper_count,
	output int                        errors,
	output int                        pending
);

	typedef struct packed {
		status_t             st;
		logic [DATA_W-1:0]   val;
		logic [COUNT_W-1:0]  lo_cnt;
		logic [COUNT_W-1:0]  up_cnt;
	} stack_rsp_t;

	logic [DATA_W-1:0] shadow_mem [DEPTH];
	int lower_fill;
	int upper_fill;
	int mis_count;
	stack_rsp_t due_rsps [$];
	stack_rsp_t want;

	assign errors = mis_count;

	function automatic stack_rsp_t apply_stack_op(op_t op, logic [DATA_W-1:0] val);
		stack_rsp_t r;
		r.st = STAT_OK;
		r.val = '0;
		case (op)
			OP_PUSH_LO: begin
				if (lower_fill + upper_fill >= DEPTH)
					r.st = STAT_OVERFLOW;
				else begin
					shadow_mem[lower_fill] = val;
					lower_fill++;
				end
			end
			OP_POP_LO: begin
				if (lower_fill == 0)
					r.st = STAT_UNDERFLOW;
				else begin
					lower_fill--;
					r.val = shadow_mem[lower_fill];
				end
			end
			OP_PUSH_UP: begin
				if (lower_fill + upper_fill >= DEPTH)
					r.st = STAT_OVERFLOW;
				else begin
					shadow_mem[DEPTH - 1 - upper_fill] = val;
					upper_fill++;
				end
			end
			default: begin
				if (upper_fill == 0)
					r.st = STAT_UNDERFLOW;
				else begin
					r.val = shadow_mem[DEPTH - upper_fill];
					upper_fill--;
				end
			end
		endcase
		r.lo_cnt = lower_fill[COUNT_W-1:0];
		r.up_cnt = upper_fill[COUNT_W-1:0];
		return r;
	endfunction

	task automatic check_field(string name, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, got_v);
			mis_count++;
		end
	endtask

	initial mis_count = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_fill = 0;
			upper_fill = 0;
			due_rsps.delete();
			pending <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (due_rsps.size() == 0) begin
					$error("response transaction with none outstanding");
					mis_count++;
				end else begin
					want = due_rsps.pop_front();
					check_field("status", want.st, status);
					check_field("pop_value", want.val, pop_value);
					check_field("lower_count", want.lo_cnt, lower_count);
					check_field("upper_count", want.up_cnt, upper_count);
				end
			end
			if (req_valid && !req_stall)
				due_rsps.push_back(apply_stack_op(op_t'(operation), push_value));
			pending <= due_rsps.size();
		end
	end

endmodule

[tb/sv/tb_top.sv]
// Testbench top for dual_stack_shared_array: clock, reset, stimulus and verdict.
// Depends on dss_pkg, the block and dss_checker.
`timescale 1ns / 100ps
module tb_top;
	import dss_pkg::*;

	localparam int DEPTH = 64;
	localparam int CYCLE_LIMIT = 200000;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      req_valid = 1'b0;
	logic                      req_stall;
	logic [1:0]                operation = OP_PUSH_LO;
	logic signed [DATA_W-1:0]  push_value = '0;
	logic                      rsp_valid;
	logic                      rsp_stall = 1'b0;
	logic [1:0]                status;
	logic signed [DATA_W-1:0]  pop_value;
	logic [COUNT_W-1:0]        lower_count;
	logic [COUNT_W-1:0]        upper_count;
	int errors;
	int pending;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_asks = 0;
	int cycles = 0;

	dual_stack_shared_array #(.DEPTH(DEPTH)) uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.operation(operation), .push_value(push_value),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.status(status), .pop_value(pop_value),
		.lower_count(lower_count), .upper_count(upper_count)
	);

	dss_checker #(.DEPTH(DEPTH)) chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.operation(operation), .push_value(push_value),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.status(status), .pop_value(pop_value),
		.lower_count(lower_count), .upper_count(upper_count),
		.errors(errors), .pending(pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("dual_stack_shared_array: mismatch");
		$finish;
	end

	// response side: random stall, or a long hold when asked
	initial begin : rsp_side
		int hold_served;
		hold_served = 0;
		forever begin
			@(posedge clk);
			if (hold_asks != hold_served) begin
				hold_served++;
				rsp_stall <= 1'b1;
				repeat (60) @(posedge clk);
			end else begin
				rsp_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	function automatic op_t pick_op(int push_pct, int lo_pct);
		logic push;
		logic lo;
		push = ($urandom_range(99) < push_pct);
		lo = ($urandom_range(99) < lo_pct);
		if (push)
			return lo ? OP_PUSH_LO : OP_PUSH_UP;
		return lo ? OP_POP_LO : OP_POP_UP;
	endfunction

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_op(op_t op, logic [DATA_W-1:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		operation <= op;
		push_value <= val;
		do @(posedge clk); while (req_stall);
	endtask

	// fill, then drain, then segments of random push/pop mix and side bias
	task automatic run_phase(int n_items);
		int done;
		int seg;
		int len;
		int push_pct;
		int lo_pct;
		done = 0;
		seg = 0;
		while (done < n_items) begin
			case (seg)
				0: begin
					push_pct = 100;
					lo_pct = 50;
					len = 70;
				end
				1: begin
					push_pct = 0;
					lo_pct = 50;
					len = 60;
				end
				default: begin
					push_pct = 10 + 20 * $urandom_range(4);
					case ($urandom_range(2))
						0: lo_pct = 50;
						1: lo_pct = 95;
						default: lo_pct = 5;
					endcase
					len = $urandom_range(60, 10);
				end
			endcase
			if (len > n_items - done)
				len = n_items - done;
			repeat (len) begin
				send_op(pick_op(push_pct, lo_pct), pick_value());
				done++;
			end
			seg++;
		end
	endtask

	task automatic drain_wait();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin : stimulus
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_op(OP_POP_LO, $urandom);
		send_op(OP_POP_UP, $urandom);
		send_op(OP_PUSH_LO, 32'h7fff_ffff);
		send_op(OP_PUSH_LO, 32'h8000_0000);
		send_op(OP_PUSH_UP, 32'hffff_ffff);
		send_op(OP_PUSH_UP, 32'h0000_0000);
		send_op(OP_PUSH_UP, 32'haaaa_aaaa);
		send_op(OP_PUSH_LO, 32'h5555_5555);
		send_op(OP_POP_LO, $urandom);
		send_op(OP_POP_UP, $urandom);
		send_op(OP_POP_UP, $urandom);
		send_op(OP_POP_UP, $urandom);
		send_op(OP_POP_UP, $urandom);
		send_op(OP_POP_LO, $urandom);
		send_op(OP_POP_LO, $urandom);
		send_op(OP_POP_LO, $urandom);
		send_op(OP_PUSH_UP, 32'h0000_0001);
		send_op(OP_POP_UP, $urandom);
		send_op(OP_PUSH_LO, 32'h0000_0002);
		send_op(OP_POP_LO, $urandom);

		send_idle_pct = 29;
		recv_idle_pct <= 67;
		run_phase(230);
		drain_wait();

		send_idle_pct = 67;
		recv_idle_pct <= 29;
		run_phase(230);

		send_idle_pct = 0;
		recv_idle_pct <= 0;
		hold_asks <= hold_asks + 1;
		run_phase(230);

		drain_wait();
		repeat (5) @(posedge clk);
		if (errors == 0)
			$display("dual_stack_shared_array: match");
		else
			$display("dual_stack_shared_array: mismatch");
		$finish;
	end

endmodule

[files.f]
rtl/dss_pkg.sv
rtl/dss_ctrl.sv
rtl/dss_datapath.sv
rtl/dual_stack_shared_array.sv
rtl/dss_checker.sv
tb/sv/dss_checker.sv
tb/sv/tb_top.sv
